### design/npc_pkg.sv
// Shared types, constants and codes for the nearest palette color block.
// Used by every module of the block; depends on nothing.
package npc_pkg;

   localparam int PALETTE_SIZE = 256;
   localparam int ADDR_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
   localparam int CHAN_W = 8;
   localparam int WORD_W = 4 * CHAN_W;
   localparam int SQ_W = 2 * CHAN_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int USED_W = 9;
   localparam int INDEX_W = 8;

   localparam logic [DIST_W-1:0] DIST_LIMIT_SQ = DIST_W'(250000);
   localparam logic [USED_W-1:0] USED_RESET = USED_W'(256);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] idx;
   } tag_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] idx;
      logic [DIST_W-1:0] distance;
   } dist_type;

   typedef struct packed {
      logic              busy;
      logic              rsp_valid;
      logic [ADDR_W-1:0] best_idx;
   } ctrl_status_type;

endpackage

### design/nearest_palette_color.sv
// Top level of the nearest palette color quantizer.
// Depends on npc_pkg, npc_mem, npc_dist and npc_ctrl.
//
// A palette word (cmd 0) is written into entry req_entry in the cycle it is
// accepted; it gives no result. A pixel word (cmd 1) holds busy high while
// the block reads palette entries 0 through used_entries-1 from the palette
// memory, one entry per cycle, and then reads back the chosen entry. A pixel
// goes through its reads, then waits while the distance pipeline empties,
// and then fetches the chosen color, which is put on the ports. A
// transparent pixel, or a search of zero entries, goes straight to the
// fetch. Busy falls at the edge that takes the result, and no new word is
// accepted while busy is high. The search time is set by the single read
// port of the palette memory and the two-stage distance pipeline that
// follows it. The result is shown for exactly one cycle with rsp_valid
// high, and the receiver must take it then: there is no way to hold it off.
// Entries searched must have been written before; the color of an entry
// that was never written is not defined. used_entries may be written only
// while busy is low; values above the palette size search the whole
// palette.

module nearest_palette_color
   import npc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [INDEX_W-1:0]  req_entry,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic [CHAN_W-1:0]   req_alpha,
   output logic                rsp_valid,
   output logic [INDEX_W-1:0]  rsp_nearest_index,
   output logic [CHAN_W-1:0]   rsp_out_red,
   output logic [CHAN_W-1:0]   rsp_out_green,
   output logic [CHAN_W-1:0]   rsp_out_blue,
   output logic [CHAN_W-1:0]   rsp_out_alpha,
   input  logic                csr_we,
   input  logic [USED_W-1:0]   csr_wdata
);

   logic [USED_W-1:0] used_entries_ff, used_entries_in;
   logic [WORD_W-1:0] req_word;
   logic [WORD_W-1:0] rd_data;
   logic [WORD_W-1:0] pixel;
   logic              wr_en;
   mem_rd_type        rd;
   tag_type           tag;
   dist_type          dist_res;
   logic              dist_busy;
   ctrl_status_type   status;

   // The user must change the configuration register only while the block is idle; the block does not enforce it.
   assign used_entries_in = csr_we ? csr_wdata : used_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_entries_ff <= USED_RESET;
      end else begin
         used_entries_ff <= used_entries_in;
      end
   end

   // Channels are packed red-high, alpha-low, as the palette words are stored.
   assign req_word = {req_red, req_green, req_blue, req_alpha};

   // A palette write goes straight to memory; an index past the palette is dropped.
   assign wr_en = start && !busy && (req_cmd == CMD_WRITE) &&
                  ((INDEX_W + 1)'(req_entry) < (INDEX_W + 1)'(PALETTE_SIZE));

   npc_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_entry)),
      .wr_data (req_word),
      .rd      (rd),
      .rd_data (rd_data)
   );

   npc_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .tag        (tag),
      .entry_word (rd_data),
      .pixel      (pixel),
      .result     (dist_res),
      .busy       (dist_busy)
   );

   npc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .cmd          (req_cmd),
      .pixel_word   (req_word),
      .used_entries (used_entries_ff),
      .dist_res     (dist_res),
      .dist_busy    (dist_busy),
      .rd           (rd),
      .tag          (tag),
      .pixel        (pixel),
      .status       (status)
   );

   assign busy = status.busy;
   assign rsp_valid = status.rsp_valid;

   // In the result cycle the memory output holds the chosen entry's color.
   assign rsp_nearest_index = INDEX_W'(status.best_idx);
   assign rsp_out_red = rd_data[4*CHAN_W-1 -: CHAN_W];
   assign rsp_out_green = rd_data[3*CHAN_W-1 -: CHAN_W];
   assign rsp_out_blue = rd_data[2*CHAN_W-1 -: CHAN_W];
   assign rsp_out_alpha = rd_data[CHAN_W-1 -: CHAN_W];

   // A result word is a single-cycle strobe.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // An accepted pixel word always keeps the block busy in the next cycle.
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_PIXEL)) |=> busy)
      else $error("pixel word accepted without starting a search");

   // The block only leaves busy by delivering a result.
   a_busy_ends_in_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> $past(rsp_valid))
      else $error("search ended without a result");

   // Palette writes never collide with a search in progress.
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd.en)
      else $error("palette write during a palette read");

endmodule

### design/npc_mem.sv
// Palette memory: one write port, one read port with registered read data.
// Depends on npc_pkg for depth and word width.
module npc_mem
   import npc_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  mem_rd_type        rd,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] palette_ff [PALETTE_SIZE];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= palette_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/npc_dist.sv
// Two-stage squared distance unit: channel squares, then their sum.
// Depends on npc_pkg for widths and the tag and result structs.
module npc_dist
   import npc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  tag_type           tag,
   input  logic [WORD_W-1:0] entry_word,
   input  logic [WORD_W-1:0] pixel,
   output dist_type          result,
   output logic              busy
);

   logic [SQ_W-1:0] sq_ff [4];
   logic [SQ_W-1:0] sq_in [4];
   tag_type         tag1_ff;
   dist_type        res_ff;
   logic [DIST_W-1:0] sum_in;

   always_comb begin
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      logic [CHAN_W-1:0] d;
      for (int c = 0; c < 4; c++) begin
         a = pixel[c*CHAN_W +: CHAN_W];
         b = entry_word[c*CHAN_W +: CHAN_W];
         d = (a > b) ? (a - b) : (b - a);
         sq_in[c] = SQ_W'(d) * SQ_W'(d);
      end
   end

   assign sum_in = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) +
                   DIST_W'(sq_ff[2]) + DIST_W'(sq_ff[3]);

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         sq_ff[c] <= sq_in[c];
      end
      tag1_ff.idx <= tag.idx;
      res_ff.idx <= tag1_ff.idx;
      res_ff.distance <= sum_in;
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         tag1_ff.valid <= tag.valid;
         res_ff.valid <= tag1_ff.valid;
      end
   end

   assign result = res_ff;
   assign busy = tag1_ff.valid | res_ff.valid;

endmodule

### design/npc_ctrl.sv
// Search sequencer: walks the palette, keeps the best entry, fetches its color.
// Depends on npc_pkg for the state enum, codes and structs.
module npc_ctrl
   import npc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              cmd,
   input  logic [WORD_W-1:0] pixel_word,
   input  logic [USED_W-1:0] used_entries,
   input  dist_type          dist_res,
   input  logic              dist_busy,
   output mem_rd_type        rd,
   output tag_type           tag,
   output logic [WORD_W-1:0] pixel,
   output ctrl_status_type   status
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [WORD_W-1:0] pix_ff, pix_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   tag_type           tag_ff, tag_in;
   logic [CNT_W-1:0]  n_sat;

   assign n_sat = (used_entries > USED_W'(PALETTE_SIZE)) ? CNT_W'(PALETTE_SIZE)
                                                         : CNT_W'(used_entries);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      pix_in = pix_ff;
      best_in = best_ff;
      best_idx_in = best_idx_ff;
      tag_in = '0;
      rd = '0;

      // A running search result is folded in whenever the distance unit delivers one.
      if (dist_res.valid && (dist_res.distance < best_ff)) begin
         best_in = dist_res.distance;
         best_idx_in = dist_res.idx;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start && (cmd == CMD_PIXEL)) begin
               pix_in = pixel_word;
               n_in = n_sat;
               cnt_in = '0;
               best_in = DIST_LIMIT_SQ;
               best_idx_in = '0;
               if ((pixel_word[CHAN_W-1:0] == '0) || (n_sat == '0)) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd.en = 1'b1;
            rd.addr = cnt_ff[ADDR_W-1:0];
            tag_in.valid = 1'b1;
            tag_in.idx = cnt_ff[ADDR_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_in == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!tag_ff.valid && !dist_busy) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rd.en = 1'b1;
            rd.addr = best_idx_ff;
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      n_ff <= n_in;
      pix_ff <= pix_in;
      best_ff <= best_in;
      best_idx_ff <= best_idx_in;
      tag_ff.idx <= tag_in.idx;
      if (reset) begin
         state_ff <= ST_IDLE;
         tag_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff.valid <= tag_in.valid;
      end
   end

   assign tag = tag_ff;
   assign pixel = pix_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.rsp_valid = (state_ff == ST_OUTPUT);
   assign status.best_idx = best_idx_ff;

endmodule

### test/tb_nearest_palette_color.sv
// Self-checking testbench for the nearest palette color quantizer.
// Depends on npc_pkg and nearest_palette_color; predicts every result and compares it.

module tb_nearest_palette_color;
   import npc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Run length: the stimulus stops once this many words have been accepted.
   localparam int unsigned ITEM_TARGET = 1100;
   // The slowest legal run is about 1100 full-palette searches plus the
   // sender's gaps. The limit is meant to lie above that.
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   // Longest pixel wait: a full palette of searched entries, then the drain and fetch.
   localparam int unsigned MAX_LATENCY = PALETTE_SIZE + 5;

   // One quantized pixel as it leaves the block.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
   } quant_result_type;

   // The scoreboard keeps its own palette and used_entries copy. Every accepted
   // word goes through note_word in acceptance order; every pixel word pushes
   // the color the block must return, and check_result pops the oldest one.
   class quantize_scoreboard;
      logic [WORD_W-1:0] palette [PALETTE_SIZE];
      bit                loaded [PALETTE_SIZE];
      logic [USED_W-1:0] used_entries;
      quant_result_type  expected_colors [$];
      int unsigned       errors;
      int unsigned       palette_writes;
      int unsigned       pixels;
      int unsigned       transparent;
      int unsigned       out_of_range;

      function new();
         used_entries = USED_RESET;
      endfunction

      function int unsigned pending();
         return expected_colors.size();
      endfunction

      // Nearest entry by squared distance over all four channels. Only
      // strictly smaller distances replace the best one, so the lowest index
      // wins a tie, and starting from the limit means an entry at exactly
      // distance 500 never qualifies.
      function quant_result_type nearest_entry(logic [WORD_W-1:0] pix);
         int unsigned        best_dist;
         int unsigned        sq_dist;
         int unsigned        span;
         int                 diff;
         logic [INDEX_W-1:0] best_idx;
         best_idx = '0;
         best_dist = 32'(DIST_LIMIT_SQ);
         if (pix[CHAN_W-1:0] == '0) begin
            transparent++;
         end else begin
            span = (used_entries > PALETTE_SIZE) ? PALETTE_SIZE : used_entries;
            for (int i = 0; i < span; i++) begin
               sq_dist = 0;
               for (int c = 0; c < 4; c++) begin
                  diff = int'(pix[c*CHAN_W +: CHAN_W]) -
                         int'(palette[i][c*CHAN_W +: CHAN_W]);
                  sq_dist += diff * diff;
               end
               if (sq_dist < best_dist) begin
                  best_dist = sq_dist;
                  best_idx = INDEX_W'(i);
               end
            end
            if (best_dist == 32'(DIST_LIMIT_SQ)) out_of_range++;
         end
         return {best_idx, palette[best_idx]};
      endfunction

      function void note_word(logic cmd, logic [INDEX_W-1:0] entry,
                              logic [WORD_W-1:0] color);
         if (cmd == CMD_WRITE) begin
            palette[entry] = color;
            loaded[entry] = 1'b1;
            palette_writes++;
         end else begin
            pixels++;
            expected_colors.push_back(nearest_entry(color));
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(quant_result_type got);
         quant_result_type want;
         if (expected_colors.size() == 0) begin
            $error("result with no pixel outstanding: index %0d", got.index);
            errors++;
         end else begin
            want = expected_colors.pop_front();
            compare_field("nearest_index", want.index, got.index);
            compare_field("out_red", want.red, got.red);
            compare_field("out_green", want.green, got.green);
            compare_field("out_blue", want.blue, got.blue);
            compare_field("out_alpha", want.alpha, got.alpha);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_cmd;
   logic [INDEX_W-1:0] req_entry;
   logic [CHAN_W-1:0]  req_red;
   logic [CHAN_W-1:0]  req_green;
   logic [CHAN_W-1:0]  req_blue;
   logic [CHAN_W-1:0]  req_alpha;
   logic               rsp_valid;
   logic [INDEX_W-1:0] rsp_nearest_index;
   logic [CHAN_W-1:0]  rsp_out_red;
   logic [CHAN_W-1:0]  rsp_out_green;
   logic [CHAN_W-1:0]  rsp_out_blue;
   logic [CHAN_W-1:0]  rsp_out_alpha;
   logic               csr_we;
   logic [USED_W-1:0]  csr_wdata;

   quantize_scoreboard sb;
   int unsigned        items_sent;
   int unsigned        burst_left;
   int unsigned        settings_tried;
   int unsigned        cycle_count;

   nearest_palette_color u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_entry         (req_entry),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_alpha         (req_alpha),
      .rsp_valid         (rsp_valid),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_out_alpha     (rsp_out_alpha),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The receiver cannot stall, so every strobed word is checked at the edge
   // that ends its cycle. Outputs are sampled before this edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_result({rsp_nearest_index, rsp_out_red, rsp_out_green,
                          rsp_out_blue, rsp_out_alpha});
      end
   end

   // Presents one word and holds it until the block takes it. Start stays high
   // across a burst, so back-to-back words only change the fields. When a
   // burst runs out, start drops for a random gap and a new burst length is
   // drawn; some bursts are long so stretches with no idling occur too.
   task automatic send_word(input logic cmd, input logic [INDEX_W-1:0] entry,
                            input logic [WORD_W-1:0] color);
      req_cmd <= cmd;
      req_entry <= entry;
      {req_red, req_green, req_blue, req_alpha} <= color;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(cmd, entry, color);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Stops sending and waits for every outstanding pixel. A palette word
   // accepted after the last pixel gives no result, so the task then also
   // waits for busy to fall before the block is treated as idle.
   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Changes used_entries; only ever done with the block idle.
   task automatic set_used(input int unsigned value);
      wait_idle();
      csr_wdata <= USED_W'(value);
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.used_entries = USED_W'(value);
      settings_tried++;
   endtask

   // Hand-picked words: boundary of the distance limit, ties, transparent
   // pixels, a search of zero entries and the extremes of every field.
   task automatic run_directed();
      set_used(2);
      send_word(CMD_WRITE, 8'd0,   {8'd255, 8'd255, 8'd255, 8'd0});
      send_word(CMD_WRITE, 8'd1,   {8'd250, 8'd250, 8'd250, 8'd0});
      send_word(CMD_WRITE, 8'd2,   {8'd0, 8'd0, 8'd0, 8'd255});
      send_word(CMD_WRITE, 8'd3,   {8'd0, 8'd0, 8'd0, 8'd255});
      send_word(CMD_WRITE, 8'd255, {8'd255, 8'd255, 8'd255, 8'd255});
      // Entry 1 sits at exactly distance 500 and entry 0 beyond it, so no
      // entry qualifies and entry 0 comes back.
      send_word(CMD_PIXEL, 8'd0,   {8'd0, 8'd0, 8'd0, 8'd250});
      // One step in blue brings entry 1 just inside the limit.
      send_word(CMD_PIXEL, 8'd255, {8'd0, 8'd0, 8'd1, 8'd250});
      send_word(CMD_PIXEL, 8'd0,   {8'd255, 8'd255, 8'd255, 8'd255});
      send_word(CMD_PIXEL, 8'd0,   {8'd255, 8'd255, 8'd255, 8'd1});
      // A transparent pixel maps to entry 0 without a search.
      send_word(CMD_PIXEL, 8'd0,   {8'd9, 8'd9, 8'd9, 8'd0});
      set_used(4);
      // Entries 2 and 3 are equal, so the lower index must win.
      send_word(CMD_PIXEL, 8'd0,   {8'd0, 8'd0, 8'd0, 8'd255});
      send_word(CMD_PIXEL, 8'd0,   {8'd1, 8'd0, 8'd0, 8'd254});
      send_word(CMD_PIXEL, 8'd0,   {8'd0, 8'd0, 8'd0, 8'd0});
      // With nothing searched the answer is entry 0 even for a perfect match.
      set_used(0);
      send_word(CMD_PIXEL, 8'd0,   {8'd0, 8'd0, 8'd0, 8'd255});
   endtask

   // One random word for a phase searching entries 0 .. span-1. About a quarter
   // are palette writes, some copying a searched color to create ties. Pixels
   // are most often close to a searched entry, plus transparent, saturated and
   // fully random ones.
   task automatic random_item(input int unsigned span);
      logic [WORD_W-1:0]  color;
      logic [INDEX_W-1:0] slot;
      int unsigned        pick;
      int                 chan;
      pick = $urandom_range(0, 99);
      color = $urandom;
      slot = INDEX_W'($urandom);
      if (pick < 25) begin
         if (pick < 12) slot = INDEX_W'($urandom_range(0, span - 1));
         if (pick < 5) color = sb.palette[$urandom_range(0, span - 1)];
         send_word(CMD_WRITE, slot, color);
      end else begin
         if (pick < 55) begin
            color = sb.palette[$urandom_range(0, span - 1)];
            for (int c = 0; c < 4; c++) begin
               chan = int'(color[c*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 6)) - 3;
               if (chan < 0) chan = 0;
               else if (chan > 255) chan = 255;
               color[c*CHAN_W +: CHAN_W] = CHAN_W'(chan);
            end
         end else if (pick < 65) begin
            color[CHAN_W-1:0] = '0;
         end else if (pick < 75) begin
            for (int c = 0; c < 4; c++) begin
               color[c*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
         end
         send_word(CMD_PIXEL, slot, color);
      end
   endtask

   // A phase sets used_entries, loads any searched entry not yet written (so
   // an undefined entry is never read) and then sends random words.
   task automatic run_phase(input int unsigned used, input int unsigned count);
      int unsigned span;
      set_used(used);
      span = (used > PALETTE_SIZE) ? PALETTE_SIZE : used;
      if (span == 0) span = 1;
      for (int i = 0; i < span; i++) begin
         if (!sb.loaded[i]) send_word(CMD_WRITE, INDEX_W'(i), $urandom);
      end
      repeat (count) random_item(span);
   endtask

   initial begin
      int unsigned used;
      int unsigned pick;
      int unsigned fixed_used [5];
      int unsigned guard;
      sb = new();
      fixed_used = '{1, 256, 511, 257, 16};
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= CMD_WRITE;
      req_entry <= '0;
      req_red <= '0;
      req_green <= '0;
      req_blue <= '0;
      req_alpha <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // The first phases hit the one-entry search, the full palette and values
      // above the palette size; the rest favor small searches to keep the run short.
      foreach (fixed_used[i]) begin
         run_phase(fixed_used[i], (fixed_used[i] > 64) ? $urandom_range(10, 25)
                                                      : $urandom_range(40, 90));
      end
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick < 13) used = $urandom_range(1, 16);
         else if (pick < 17) used = $urandom_range(17, 64);
         else if (pick < 18) used = 0;
         else if (pick < 19) used = 256;
         else used = $urandom_range(257, 511);
         run_phase(used, (used > 64) ? $urandom_range(10, 25) : $urandom_range(40, 90));
      end

      // Let the last results arrive; anything still outstanding afterwards is lost.
      start <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 4 * MAX_LATENCY) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d pixel results never arrived", sb.pending());
         sb.errors += sb.pending();
      end

      $display("Covered %0d pixels (%0d transparent, %0d with no entry in range)",
               sb.pixels, sb.transparent, sb.out_of_range);
      $display("and %0d palette writes over %0d used_entries settings, from 0 up to %s",
               sb.palette_writes, settings_tried, "values beyond the palette size.");
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
